FILE: sv/threshold_erosion_window_top_assert.svh
`ifndef THRESHOLD_EROSION_WINDOW_TOP_ASSERT_SVH
`define THRESHOLD_EROSION_WINDOW_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TEW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TEW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tew_pkg.sv
`timescale 1ns / 1ps

package tew_pkg;

    // field and register widths
    localparam int PIX_W      = 16;
    localparam int THR_W      = 16;
    localparam int IW_W       = 11;
    localparam int IH_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // default geometry
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_RADIUS    = 4;

    // register reset values
    localparam logic [THR_W-1:0] RST_THRESHOLD = '0;
    localparam logic [IW_W-1:0]  RST_WIDTH     = IW_W'(640);
    localparam logic [IH_W-1:0]  RST_HEIGHT    = IH_W'(480);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } t_cfg_idx;

    // per-item info carried from the scan stage to the erosion stage
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             ok;
        logic             row0;
        logic             col0;
        logic             interior;
    } t_s1_info;

endpackage

FILE: sv/tew_col_mem.sv
`timescale 1ns / 1ps

module tew_col_mem
    import tew_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEF_MAX_WIDTH),
    parameter int DW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    output logic          o_busy
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // clearing sweep after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

FILE: sv/tew_scan.sv
`timescale 1ns / 1ps

module tew_scan
    import tew_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int RADIUS    = DEF_RADIUS,
    parameter int CW        = $clog2(DEF_MAX_WIDTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_adv,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic [THR_W-1:0] i_threshold,
    input  logic [IW_W-1:0]  i_width,
    input  logic [IH_W-1:0]  i_height,
    output logic [CW-1:0]    o_rd_addr,
    output logic             o_s1_valid,
    output t_s1_info         o_s1,
    output logic [CW-1:0]    o_s1_col
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (IW_W > WW) ? IW_W : WW;

    logic [CW-1:0]    r_col;
    logic [IH_W-1:0]  r_row;
    logic [CW-1:0]    n_col;
    logic [IH_W-1:0]  n_row;
    logic             r_s1_valid;
    t_s1_info         r_s1;
    logic [CW-1:0]    r_s1_col;
    t_s1_info         n_s1;

    logic [CMP_W-1:0] w_ext;
    logic [CMP_W-1:0] eff_w;
    logic [IH_W-1:0]  eff_h;
    logic [CMP_W:0]   col_wide;
    logic [IH_W:0]    row_wide;
    logic             col_end;
    logic             row_end;
    logic             col_in;
    logic             row_in;

    // effective frame size: zero counts as one, width saturates at the line store
    always_comb begin
        w_ext = CMP_W'(i_width);
        if (w_ext == '0) begin
            eff_w = CMP_W'(1);
        end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
            eff_w = CMP_W'(MAX_WIDTH);
        end else begin
            eff_w = w_ext;
        end
        eff_h = (i_height == '0) ? IH_W'(1) : i_height;
    end

    // position tests
    always_comb begin
        col_wide = (CMP_W + 1)'(r_col);
        row_wide = (IH_W + 1)'(r_row);
        col_end  = (col_wide + (CMP_W + 1)'(1)) >= (CMP_W + 1)'(eff_w);
        row_end  = (row_wide + (IH_W + 1)'(1)) >= (IH_W + 1)'(eff_h);
        col_in   = (col_wide >= (CMP_W + 1)'(RADIUS)) &&
                   ((col_wide + (CMP_W + 1)'(RADIUS)) < (CMP_W + 1)'(eff_w));
        row_in   = (row_wide >= (IH_W + 1)'(RADIUS)) &&
                   ((row_wide + (IH_W + 1)'(RADIUS)) < (IH_W + 1)'(eff_h));

        n_s1.pix      = i_pixel;
        n_s1.ok       = i_pixel >= i_threshold;
        n_s1.row0     = r_row == '0;
        n_s1.col0     = r_col == '0;
        n_s1.interior = col_in && row_in;

        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    // raster counters and stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_s1_valid <= 1'b1;
            end else if (i_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1     <= n_s1;
            r_s1_col <= r_col;
        end
    end

    assign o_rd_addr  = r_col;
    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;
    assign o_s1_col   = r_s1_col;

endmodule

FILE: sv/tew_erode.sv
`timescale 1ns / 1ps

module tew_erode
    import tew_pkg::*;
#(
    parameter int RADIUS = DEF_RADIUS,
    parameter int CW     = $clog2(DEF_MAX_WIDTH),
    parameter int RUN_W  = $clog2(DEF_RADIUS + 2)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [CW-1:0]    i_rd_addr,
    input  logic             i_s1_valid,
    input  t_s1_info         i_s1,
    input  logic [CW-1:0]    i_s1_col,
    input  logic [RUN_W-1:0] i_rd_data,
    input  logic             i_out_stall,
    output logic             o_adv,
    output logic             o_wr_en,
    output logic [CW-1:0]    o_wr_addr,
    output logic [RUN_W-1:0] o_wr_data,
    output logic             o_out_valid,
    output logic [PIX_W-1:0] o_out_pixel,
    output logic             o_written
);

    localparam logic [RUN_W-1:0] FULL_RUN = RUN_W'(RADIUS + 1);

    logic [RUN_W-1:0] r_row_run;
    logic             r_byp_hit;
    logic [RUN_W-1:0] r_byp_val;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_written;

    logic             adv;
    logic [RUN_W-1:0] c_prev;
    logic [RUN_W-1:0] r_prev;
    logic [RUN_W-1:0] n_col_run;
    logic [RUN_W-1:0] n_row_run;
    logic [PIX_W-1:0] n_out_pixel;

    assign adv = i_s1_valid && (!r_out_valid || !i_out_stall);

    // saturating runs; the bypass covers a write to the address read in the same cycle
    always_comb begin
        if (i_s1.row0) begin
            c_prev = '0;
        end else if (r_byp_hit) begin
            c_prev = r_byp_val;
        end else begin
            c_prev = i_rd_data;
        end
        r_prev = i_s1.col0 ? '0 : r_row_run;

        if (!i_s1.ok) begin
            n_col_run = '0;
        end else if (c_prev >= FULL_RUN) begin
            n_col_run = FULL_RUN;
        end else begin
            n_col_run = c_prev + 1'b1;
        end

        if (n_col_run < FULL_RUN) begin
            n_row_run = '0;
        end else if (r_prev >= FULL_RUN) begin
            n_row_run = FULL_RUN;
        end else begin
            n_row_run = r_prev + 1'b1;
        end

        n_out_pixel = (i_s1.interior && n_row_run >= FULL_RUN) ? i_s1.pix : '0;
    end

    // row run and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_run   <= '0;
            r_byp_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_row_run   <= n_row_run;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_accept) begin
                r_byp_hit <= adv && (i_rd_addr == i_s1_col);
            end
        end
    end

    // result payload and bypass value
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_pixel <= n_out_pixel;
            r_written   <= i_s1.interior;
        end
        if (i_accept) begin
            r_byp_val <= n_col_run;
        end
    end

    assign o_adv       = adv;
    assign o_wr_en     = adv;
    assign o_wr_addr   = i_s1_col;
    assign o_wr_data   = n_col_run;
    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_written   = r_written;

endmodule

FILE: sv/threshold_erosion_window_top.sv
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+------------------------
// input    | in        | i_in_valid / o_in_stall   | i_pixel
// result   | out       | o_out_valid / i_out_stall | o_out_pixel, o_written
// config   | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// one pixel per cycle sustained while the result side does not stall and the line store is not clearing;
// a taken pixel passes the scan stage register (column run read from the line store), then the result register
// the line store of column runs has one write and one read port, one access of each per item
// after reset the line store is cleared entry by entry, with o_in_stall held high
// a stalled result holds while one more item waits in the erosion stage

`timescale 1ns / 1ps

`include "threshold_erosion_window_top_assert.svh"

module threshold_erosion_window_top
    import tew_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int RADIUS    = DEF_RADIUS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_out_pixel,
    output logic                  o_written
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RUN_W = $clog2(RADIUS + 2);

    logic [THR_W-1:0] r_threshold;
    logic [IW_W-1:0]  r_width;
    logic [IH_W-1:0]  r_height;

    logic             accept;
    logic             adv;
    logic             mem_busy;
    logic [CW-1:0]    rd_addr;
    logic             s1_valid;
    t_s1_info         s1;
    logic [CW-1:0]    s1_col;
    logic [RUN_W-1:0] rd_data;
    logic             wr_en;
    logic [CW-1:0]    wr_addr;
    logic [RUN_W-1:0] wr_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                CFG_WIDTH:     r_width     <= i_cfg_data[IW_W-1:0];
                CFG_HEIGHT:    r_height    <= i_cfg_data[IH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input handshake
    assign o_in_stall = mem_busy || (s1_valid && !adv);
    assign accept     = i_in_valid && !o_in_stall;

    tew_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS),
        .CW        (CW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_adv       (adv),
        .i_pixel     (i_pixel),
        .i_threshold (r_threshold),
        .i_width     (r_width),
        .i_height    (r_height),
        .o_rd_addr   (rd_addr),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1),
        .o_s1_col    (s1_col)
    );

    tew_col_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (RUN_W)
    ) u_col_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_busy    (mem_busy)
    );

    tew_erode #(
        .RADIUS (RADIUS),
        .CW     (CW),
        .RUN_W  (RUN_W)
    ) u_erode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rd_addr   (rd_addr),
        .i_s1_valid  (s1_valid),
        .i_s1        (s1),
        .i_s1_col    (s1_col),
        .i_rd_data   (rd_data),
        .i_out_stall (i_out_stall),
        .o_adv       (adv),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (o_out_valid),
        .o_out_pixel (o_out_pixel),
        .o_written   (o_written)
    );

    // checks
    `TEW_ASSERT_NOW(a_border_zero, i_clk, i_rst_n, o_out_valid && !o_written, o_out_pixel == '0, "border item carries a nonzero pixel")
    `TEW_ASSERT_NOW(a_no_work_in_clear, i_clk, i_rst_n, mem_busy, !s1_valid && !wr_en, "item in flight during line store clear")
    `TEW_ASSERT_NEXT(a_accept_fills_stage, i_clk, i_rst_n, accept, s1_valid, "accepted item missing from erosion stage")

endmodule
